>>> rtl/u8u16_pkg.sv
// Package for the UTF-8 to UTF-16 stream decoder.
// Holds the shared types, result codes and byte-class constants. No dependencies.
package u8u16_pkg;

	typedef enum logic [1:0] {
		ST_CHAR      = 2'd0,
		ST_END_OK    = 2'd1,
		ST_END_TRUNC = 2'd2
	} status_t;

	localparam logic [1:0] PEND_NONE = 2'd0;
	localparam logic [1:0] PEND_ONE  = 2'd1;
	localparam logic [1:0] PEND_TWO  = 2'd2;

	localparam logic [7:0] BYTE_TERM  = 8'h00;
	localparam logic [7:0] LEAD_MULTI = 8'h80;
	localparam logic [7:0] LEAD_THREE = 8'hE0;

	localparam logic [15:0] MAX_UNITS_RESET = 16'hFFFF;

	// One decoded result handed from the step logic to the result register.
	typedef struct packed {
		logic        emit;
		logic [15:0] code_unit;
		status_t     status;
	} step_res_t;

endpackage

>>> rtl/utf8_to_utf16_stream_decoder_top.sv
// Top level of the UTF-8 to UTF-16 (BMP) stream decoder.
// Depends on u8u16_pkg, u8u16_step and u8u16_out_reg.
//
// Channel   Direction  Handshake            Payload
// in        consumer   in_valid/in_ready    in_byte[7:0]
// out       producer   out_valid/out_ready  code_unit[15:0], status[1:0]
// cfg       consumer   cfg_valid/cfg_ready  cfg_data[15:0] (max_units)
//
// One byte is accepted per cycle unless a held byte waits. A request's result
// passes through the input register and then the result register to reach out.
// The rate is set by the state update in the step logic.
// A byte that yields a result waits in the input register while the result
// register is full and not taken; bytes that yield nothing never wait.
// Reset is asynchronous: string state clears and max_units returns to 65535.
module utf8_to_utf16_stream_decoder_top import u8u16_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] code_unit,
	output logic [1:0]  status,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic [15:0] max_units_q;
	step_res_t   res;
	logic        out_free;
	logic        fire_s1;

	// Register writes are always taken; the user must write only while idle, the block does not enforce it.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_units_q <= MAX_UNITS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_units_q <= cfg_data;
		end
	end

	// Advance the held byte unless its result has nowhere to go.
	assign fire_s1  = valid_s1 && (!res.emit || out_free);
	assign in_ready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
		end
	end

	u8u16_step u_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire_s1),
		.in_byte   (byte_s1),
		.max_units (max_units_q),
		.res       (res)
	);

	u8u16_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (fire_s1 && res.emit),
		.din       (res),
		.out_ready (out_ready),
		.free      (out_free),
		.out_valid (out_valid),
		.code_unit (code_unit),
		.status    (status)
	);

`ifndef SYNTH
	// End-of-string results carry a zero code unit.
	a_end_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_CHAR |-> code_unit == 16'd0)
		else $error("end result with nonzero code unit");

	// Zero values are dropped, so a character result is never zero.
	a_char_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_CHAR |-> code_unit != 16'd0)
		else $error("character result with zero code unit");

	// A terminator that advances lands in the result register as an end result.
	a_term_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && byte_s1 == BYTE_TERM |=> out_valid && status != ST_CHAR)
		else $error("terminator did not produce an end result");
`endif

endmodule

>>> rtl/u8u16_step.sv
// Per-byte decode step and per-string state registers.
// Depends on u8u16_pkg.
module u8u16_step import u8u16_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        fire,
	input  logic [7:0]  in_byte,
	input  logic [15:0] max_units,
	output step_res_t   res
);

	logic [7:0]  first_byte_q, second_byte_q;
	logic [1:0]  pend_q;
	logic [15:0] units_q;
	logic        limit_q;

	logic [7:0]  first_byte_d, second_byte_d;
	logic [1:0]  pend_d;
	logic [15:0] units_d;
	logic        limit_d;

	logic        complete;
	logic [15:0] val;

	always_comb begin
		first_byte_d  = first_byte_q;
		second_byte_d = second_byte_q;
		pend_d        = pend_q;
		units_d       = units_q;
		limit_d       = limit_q;
		complete      = 1'b0;
		val           = 16'd0;
		res.emit      = 1'b0;
		res.code_unit = 16'd0;
		res.status    = ST_CHAR;

		if (in_byte == BYTE_TERM) begin
			// Terminator always reports, then clear the string state.
			res.emit      = 1'b1;
			res.status    = (!limit_q && pend_q != PEND_NONE) ? ST_END_TRUNC : ST_END_OK;
			first_byte_d  = 8'd0;
			second_byte_d = 8'd0;
			pend_d        = PEND_NONE;
			units_d       = 16'd0;
			limit_d       = 1'b0;
		end else if (!limit_q) begin
			unique case (pend_q)
				PEND_NONE: begin
					if (in_byte < LEAD_MULTI) begin
						val      = {8'd0, in_byte};
						complete = 1'b1;
					end else begin
						first_byte_d = in_byte;
						pend_d       = (in_byte < LEAD_THREE) ? PEND_ONE : PEND_TWO;
					end
				end
				PEND_ONE: begin
					pend_d   = PEND_NONE;
					complete = 1'b1;
					if (first_byte_q < LEAD_THREE)
						val = {5'd0, first_byte_q[4:0], in_byte[5:0]};
					else
						val = {first_byte_q[3:0], second_byte_q[5:0], in_byte[5:0]};
				end
				default: begin
					// Two pending (three treated alike): hold the middle byte.
					second_byte_d = in_byte;
					pend_d        = PEND_ONE;
				end
			endcase

			if (complete && val != 16'd0) begin
				if (units_q >= max_units) begin
					limit_d = 1'b1;
					pend_d  = PEND_NONE;
				end else begin
					units_d       = units_q + 16'd1;
					res.emit      = 1'b1;
					res.code_unit = val;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_byte_q  <= 8'd0;
			second_byte_q <= 8'd0;
			pend_q        <= PEND_NONE;
			units_q       <= 16'd0;
			limit_q       <= 1'b0;
		end else if (fire) begin
			first_byte_q  <= first_byte_d;
			second_byte_q <= second_byte_d;
			pend_q        <= pend_d;
			units_q       <= units_d;
			limit_q       <= limit_d;
		end
	end

endmodule

>>> rtl/u8u16_out_reg.sv
// Result register with valid/ready toward the consumer.
// Depends on u8u16_pkg.
module u8u16_out_reg import u8u16_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  step_res_t   din,
	input  logic        out_ready,
	output logic        free,
	output logic        out_valid,
	output logic [15:0] code_unit,
	output logic [1:0]  status
);

	logic        valid_q;
	logic [15:0] code_q;
	status_t     status_q;

	// Slot can take a new result when empty or drained this cycle.
	assign free = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			code_q   <= din.code_unit;
			status_q <= din.status;
		end
	end

	assign out_valid = valid_q;
	assign code_unit = code_q;
	assign status    = status_q;

endmodule

>>> test/testbench.sv
// Self-checking testbench for utf8_to_utf16_stream_decoder_top.
// Uses types and constants from u8u16_pkg and needs the decoder's RTL; it generates
// the requests, predicts every code unit itself and checks each result.
module testbench;
	import u8u16_pkg::*;

	// Cap on cycles in a row with no accepted request anywhere.
	localparam int WATCHDOG_LIMIT = 2000;
	// Let a byte still sitting in the input or result register settle.
	localparam int DRAIN_CYCLES   = 4;

	typedef struct packed {
		logic [15:0] code_unit;
		status_t     status;
	} unit_rec_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  in_byte = 8'h00;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [15:0] code_unit;
	logic [1:0]  status;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = 16'h0000;

	utf8_to_utf16_stream_decoder_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_byte   (in_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.code_unit (code_unit),
		.status    (status),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// Code units the decoder owes us, oldest first.
	unit_rec_t units_due[$];
	unit_rec_t due;

	// Shadow of the decoder: register plus per-string state.
	logic [15:0] cfg_max_units = MAX_UNITS_RESET;
	logic [7:0]  seq_lead      = 8'h00;
	logic [7:0]  seq_mid       = 8'h00;
	logic [1:0]  seq_pending   = PEND_NONE;
	logic [15:0] str_units     = 16'h0000;
	logic        str_limited   = 1'b0;

	// Traffic shaping knobs, set per test.
	int send_gap_max = 0;
	int burst_left   = 0;
	int rx_stall_max = 0;
	int rx_run_left  = 0;
	int rx_hold      = 0;

	int errors       = 0;
	int stuck_cycles = 0;
	int n_bytes      = 0;
	int n_strings    = 0;
	int n_results    = 0;
	int n_limit_hits = 0;
	int n_cfg_writes = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	// Advance the shadow state by one accepted byte and queue any code unit it yields.
	task automatic decode_byte(input logic [7:0] b);
		logic [15:0] value;
		logic        done;
		value = 16'h0000;
		done  = 1'b0;
		if (b == BYTE_TERM) begin
			// Terminator: ok unless a sequence is still open and the limit never hit.
			units_due.push_back('{16'h0000,
				(!str_limited && seq_pending != PEND_NONE) ? ST_END_TRUNC : ST_END_OK});
			seq_lead    = 8'h00;
			seq_mid     = 8'h00;
			seq_pending = PEND_NONE;
			str_units   = 16'h0000;
			str_limited = 1'b0;
			n_strings++;
		end else if (!str_limited) begin
			if (seq_pending == PEND_NONE) begin
				if (b < LEAD_MULTI) begin
					value = {8'h00, b};
					done  = 1'b1;
				end else begin
					seq_lead    = b;
					seq_pending = (b < LEAD_THREE) ? PEND_ONE : PEND_TWO;
				end
			end else if (seq_pending != PEND_ONE) begin
				seq_mid     = b;
				seq_pending = PEND_ONE;
			end else begin
				// Continuation bytes are taken as they come: only the low six bits count.
				seq_pending = PEND_NONE;
				done        = 1'b1;
				if (seq_lead < LEAD_THREE)
					value = {5'b00000, seq_lead[4:0], b[5:0]};
				else
					value = {seq_lead[3:0], seq_mid[5:0], b[5:0]};
			end
			// A zero value is dropped and does not count toward the limit.
			if (done && value != 16'h0000) begin
				if (str_units >= cfg_max_units) begin
					str_limited = 1'b1;
					seq_pending = PEND_NONE;
					n_limit_hits++;
				end else begin
					str_units = str_units + 16'h0001;
					units_due.push_back('{value, ST_CHAR});
				end
			end
		end
	endtask

	// Offer one byte; bursts of random length separated by random gaps.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = (send_gap_max == 0) ? 0 : $urandom_range(0, send_gap_max);
			if (gap != 0) begin
				@(negedge clk);
				in_valid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid = 1'b1;
		in_byte  = b;
		// Hold the request until the decoder takes it.
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		decode_byte(b);
		n_bytes++;
	endtask

	// Write max_units once the decoder has gone quiet.
	task automatic write_max_units(input logic [15:0] value);
		@(negedge clk);
		in_valid   = 1'b0;
		burst_left = 0;
		while (units_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data  = value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_max_units = value;
		n_cfg_writes++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic logic [7:0] cont_byte();
		// Mostly proper continuations, sometimes any nonzero byte.
		if ($urandom_range(0, 9) < 8)
			return 8'h80 | 8'($urandom_range(0, 63));
		return 8'($urandom_range(1, 255));
	endfunction

	// One random string: mostly well-formed characters, some noise, some cut short.
	task automatic send_random_string();
		int n_chars;
		int roll;
		logic broken;
		n_chars = $urandom_range(0, 16);
		broken  = 1'b0;
		for (int i = 0; i < n_chars && !broken; i++) begin
			roll = $urandom_range(0, 99);
			if (roll < 35) begin
				send_byte(8'($urandom_range(1, 127)));
			end else if (roll < 60) begin
				send_byte(8'($urandom_range(128, 223)));
				send_byte(cont_byte());
			end else if (roll < 85) begin
				send_byte(8'($urandom_range(224, 255)));
				send_byte(cont_byte());
				send_byte(cont_byte());
			end else if (roll < 95) begin
				send_byte(8'($urandom_range(1, 255)));
			end else begin
				// Open a sequence and end the string inside it.
				send_byte(8'($urandom_range(128, 255)));
				if ($urandom_range(0, 1) == 1 && !broken)
					send_byte(cont_byte());
				broken = 1'b1;
			end
		end
		send_byte(BYTE_TERM);
	endtask

	task automatic test_single_bytes();
		send_gap_max = 0;
		rx_stall_max = 0;
		write_max_units(MAX_UNITS_RESET);
		send_byte(8'h01);
		send_byte(8'h7F);
		send_byte(BYTE_TERM);
	endtask

	task automatic test_multi_byte();
		send_gap_max = 3;
		rx_stall_max = 3;
		// Two-byte extremes, then a two-byte sequence that decodes to zero.
		send_byte(8'hC2); send_byte(8'h80);
		send_byte(8'hDF); send_byte(8'hBF);
		send_byte(8'h80); send_byte(8'h80);
		// Three-byte zero and three-byte maximum.
		send_byte(8'hE0); send_byte(8'h80); send_byte(8'h80);
		send_byte(8'hEF); send_byte(8'hBF); send_byte(8'hBF);
		// Continuation not checked.
		send_byte(8'hC3); send_byte(8'h41);
		send_byte(BYTE_TERM);
	endtask

	task automatic test_truncation();
		send_byte(8'hC3);
		send_byte(BYTE_TERM);
		send_byte(8'hE2); send_byte(8'h82);
		send_byte(BYTE_TERM);
	endtask

	task automatic test_unit_limit();
		// Third character hits the limit; the open lead after it is dropped.
		write_max_units(16'h0002);
		send_byte(8'h41); send_byte(8'h42); send_byte(8'h43);
		send_byte(8'hC3);
		send_byte(BYTE_TERM);
		// Zero limit: the first nonzero character already hits it.
		write_max_units(16'h0000);
		send_byte(8'h41);
		send_byte(BYTE_TERM);
		// Lower the limit under the count of a string in progress.
		write_max_units(MAX_UNITS_RESET);
		send_byte(8'h41); send_byte(8'h42);
		write_max_units(16'h0001);
		send_byte(8'h44);
		send_byte(BYTE_TERM);
	endtask

	task automatic test_backpressure();
		write_max_units(MAX_UNITS_RESET);
		send_gap_max = 0;
		rx_stall_max = 0;
		// Stop the receiver for a long stretch and keep offering characters.
		rx_hold = 300;
		for (int i = 0; i < 40; i++)
			send_byte(8'($urandom_range(1, 127)));
		send_byte(BYTE_TERM);
	endtask

	task automatic test_random_strings();
		logic [15:0] limits [7];
		int          phase_start;
		limits = '{16'hFFFF, 16'h0000, 16'h0001, 16'h0003, 16'h0008, 16'h0000, 16'hFFFF};
		limits[5] = 16'($urandom_range(0, 65535));
		for (int p = 0; p < 7; p++) begin
			write_max_units(limits[p]);
			send_gap_max = (p % 3 == 1 || p == 6) ? 0 : $urandom_range(1, 8);
			rx_stall_max = (p % 3 == 2 || p == 6) ? 0 : $urandom_range(1, 8);
			phase_start = n_bytes;
			while (n_bytes - phase_start < 140)
				send_random_string();
		end
	endtask

	// Receiver: alternate runs of ready and stall of random length; honor a hold-off.
	initial begin
		forever begin
			@(negedge clk);
			if (rx_hold != 0) begin
				out_ready = 1'b0;
				rx_hold--;
			end else if (rx_stall_max == 0) begin
				out_ready = 1'b1;
			end else if (rx_run_left != 0) begin
				rx_run_left--;
			end else begin
				out_ready   = !out_ready;
				rx_run_left = out_ready ? $urandom_range(0, 12) : $urandom_range(0, rx_stall_max - 1);
			end
		end
	end

	// Check every accepted result against the oldest expected code unit.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (units_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected result code_unit=%h status=%0d",
					$time, code_unit, status);
			end else begin
				due = units_due.pop_front();
				n_results++;
				if (code_unit !== due.code_unit || status !== due.status) begin
					errors++;
					$display("%0t: mismatch expected code_unit=%h status=%0d, got code_unit=%h status=%0d",
						$time, due.code_unit, due.status, code_unit, status);
				end
			end
		end
	end

	// Watchdog: end the run if no request moves on any channel for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			stuck_cycles = 0;
		else
			stuck_cycles++;
		if (stuck_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog, no request accepted for %0d cycles, %0d results still due",
				$time, stuck_cycles, units_due.size());
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		// Hold reset, then release it between edges.
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_single_bytes();
		test_multi_byte();
		test_truncation();
		test_unit_limit();
		test_backpressure();
		test_random_strings();

		// Drop the input, drain what is owed, then give the pipeline time to misbehave.
		@(negedge clk);
		in_valid = 1'b0;
		while (units_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES * 4) @(posedge clk);

		$display("Sent %0d bytes in %0d strings, checked %0d results.",
			n_bytes, n_strings, n_results);
		$display("Hit the unit limit %0d times over %0d max_units writes.",
			n_limit_hits, n_cfg_writes);
		if (errors == 0 && units_due.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

>>> sim.f
rtl/u8u16_pkg.sv
rtl/u8u16_step.sv
rtl/u8u16_out_reg.sv
rtl/utf8_to_utf16_stream_decoder_top.sv
test/testbench.sv
